FILE: hdl/dip_stream_aware_cache_replacement_macros.svh
// Assertion macros shared by the replacement engine.
// Every macro samples on aclk and is switched off while aresetn is low.
`ifndef DIP_STREAM_AWARE_CACHE_REPLACEMENT_MACROS_SVH
`define DIP_STREAM_AWARE_CACHE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSACR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSACR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dsacr_pkg.sv
package dsacr_pkg;

    // Default geometry of the cache.
    localparam int NUM_SETS_DEF = 2048;
    localparam int NUM_WAYS_DEF = 16;

    // Set-dueling grouping and policy selector range.
    localparam int LEADER_GROUP = 64;
    localparam int SELECTOR_MAX = 1023;
    localparam int SELECTOR_W   = $clog2(SELECTOR_MAX + 1);

    // Field widths of a beat.
    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int ADDR_W    = 16;
    localparam int THRESH_W  = 8;
    localparam int STREAK_W  = 8;
    localparam int BIMODAL_W = 5;
    localparam int DECAY_W   = 12;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd4;

    // Command codes carried in the input tuser.
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Re-reference prediction values used on insertion and promotion.
    localparam logic [1:0] RRPV_NEAR = 2'd0;
    localparam logic [1:0] RRPV_MAX  = 2'd3;

    // One row of the per-set stride detector.
    typedef struct packed {
        logic [ADDR_W-1:0]   last_addr;
        logic [ADDR_W-1:0]   prev_delta;
        logic [STREAK_W-1:0] streak;
    } stride_row_t;

endpackage

FILE: hdl/dip_stream_aware_cache_replacement.sv
// Channel   | Direction | Beat contents (lowest bit first)
// s_        | in        | tdata: set_index[10:0], way[14:11], address[30:15], zero[31]
//           |           | tuser: cmd[0], hit[1]
// m_        | out       | tdata: victim_way[3:0], zero[7:4]; tuser: stream_detected
// cfg_      | in        | cfg_data: stream_threshold[7:0]
//
// A victim query goes through a range fold, a set-row read, then the shared level-compare
// unit, which tests one RRPV level per cycle (one to five passes), and a load of the
// output register, after which its result can be taken.
// An update goes through range fold, row read, an execute step that writes the rows back,
// then the output register load.
// A set_index at or above NUM_SETS is folded into range by subtracting NUM_SETS.
// After reset a clearing pass clears all row memories; after every 4096th update one
// clears the reuse memory only. s_tready is low during it, configuration is still taken.
// A waiting result in the output register holds the next result back until it is taken.
module dip_stream_aware_cache_replacement #(
    parameter int NUM_SETS = dsacr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = dsacr_pkg::NUM_WAYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // set_index, way, address bits, zero pad
    input  logic [1:0]  s_tuser,   // cmd, hit
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // victim_way, zero pad
    output logic        m_tuser,   // stream_detected
    // Threshold register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // stream_threshold
);

    `include "dip_stream_aware_cache_replacement_macros.svh"

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W = 2 * NUM_WAYS;
    localparam int GRP_W = $clog2(dsacr_pkg::LEADER_GROUP);
    localparam int SIN_W = dsacr_pkg::SET_IN_W;
    localparam int WIN_W = dsacr_pkg::WAY_IN_W;
    localparam int SEL_W = dsacr_pkg::SELECTOR_W;

    localparam logic [SET_W-1:0] SWEEP_LAST = SET_W'(NUM_SETS - 1);
    localparam logic [SEL_W-1:0] SEL_MAX    = SEL_W'(dsacr_pkg::SELECTOR_MAX);
    localparam logic [SEL_W-1:0] SEL_RESET  = SEL_W'(dsacr_pkg::SELECTOR_MAX / 2);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_EXEC   = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_SWEEP  = 3'd6;

    // Scan steps: levels 3 to 0 among ways not reused, then level 3 among all ways.
    localparam logic [2:0] SCAN_FALLBACK = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic                             cmd_reg, cmd_next;
    logic                             hit_reg, hit_next;
    logic [SIN_W-1:0]                 set_reg, set_next;
    logic [WIN_W-1:0]                 way_reg, way_next;
    logic [dsacr_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [2:0]                       step_reg, step_next;
    logic [SET_W-1:0]                 sweep_cnt_reg, sweep_cnt_next;
    logic                             sweep_full_reg, sweep_full_next;
    logic                             decay_wrap_reg, decay_wrap_next;
    logic [WAY_W-1:0]                 victim_reg, victim_next;
    logic                             stream_reg, stream_next;
    logic [dsacr_pkg::THRESH_W-1:0]   thresh_reg, thresh_next;
    logic [SEL_W-1:0]                 sel_reg, sel_next;
    logic [dsacr_pkg::BIMODAL_W-1:0]  bim_reg, bim_next;
    logic [dsacr_pkg::DECAY_W-1:0]    decay_reg, decay_next;
    logic                             m_valid_reg, m_valid_next;
    logic [WIN_W-1:0]                 m_way_reg, m_way_next;
    logic                             m_stream_reg, m_stream_next;

    // Row memories, one row per set.
    logic [ROW_W-1:0]             rrpv_mem   [NUM_SETS];
    logic [NUM_WAYS-1:0]          reuse_mem  [NUM_SETS];
    dsacr_pkg::stride_row_t       stride_mem [NUM_SETS];
    logic [ROW_W-1:0]             rrpv_rd_reg;
    logic [NUM_WAYS-1:0]          reuse_rd_reg;
    dsacr_pkg::stride_row_t       stride_rd_reg;

    logic [SET_W-1:0]             set_addr;
    logic [WAY_W-1:0]             way_idx;
    logic                         set_in_range, way_in_range;
    logic                         rd_en;
    logic                         rrpv_we, reuse_we, stride_we;
    logic [SET_W-1:0]             wr_addr;
    logic [ROW_W-1:0]             rrpv_wd, rrpv_upd;
    logic [NUM_WAYS-1:0]          reuse_wd, reuse_upd;
    dsacr_pkg::stride_row_t       stride_wd, stride_upd;

    logic [1:0]                   scan_level;
    logic [NUM_WAYS-1:0]          scan_match;
    logic                         scan_found;
    logic [WAY_W-1:0]             scan_way;

    logic [dsacr_pkg::ADDR_W-1:0]    delta;
    logic [dsacr_pkg::STREAK_W-1:0]  streak_inc;
    logic                            stride_repeat;
    logic                            stream_calc;
    logic                            lip_leader;
    logic                            bip_fill;
    logic [dsacr_pkg::BIMODAL_W-1:0] bim_inc;
    logic [1:0]                      fill_val;
    logic [dsacr_pkg::DECAY_W-1:0]   decay_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, m_way_reg};
    assign m_tuser   = m_stream_reg;

    // Item address into the row memories once the set has been brought into range.
    assign set_in_range = 32'(set_reg) < NUM_SETS;
    assign way_in_range = 32'(way_reg) < NUM_WAYS;
    assign set_addr     = SET_W'(set_reg);
    assign way_idx      = WAY_W'(way_reg);
    assign lip_leader   = !set_reg[GRP_W-1];

    // Shared level-compare unit: one RRPV level tested across all ways per cycle.
    assign scan_level = (step_reg == SCAN_FALLBACK) ? dsacr_pkg::RRPV_MAX
                                                    : dsacr_pkg::RRPV_MAX - step_reg[1:0];
    always_comb begin
        scan_found = 1'b0;
        scan_way   = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            scan_match[i] = (rrpv_rd_reg[2*i +: 2] == scan_level)
                            && (!reuse_rd_reg[i] || (step_reg == SCAN_FALLBACK));
        end
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (scan_match[i]) begin
                scan_found = 1'b1;
                scan_way   = WAY_W'(i);
            end
        end
    end

    // Stride detector and insertion policy for an update.
    always_comb begin
        delta         = addr_reg - stride_rd_reg.last_addr;
        streak_inc    = stride_rd_reg.streak + 8'd1;
        stride_repeat = (stride_rd_reg.streak != '0) && (delta == stride_rd_reg.prev_delta)
                        && (delta != '0);
        stream_calc   = stride_repeat && (streak_inc >= thresh_reg);

        stride_upd.last_addr  = addr_reg;
        stride_upd.prev_delta = delta;
        stride_upd.streak     = stride_repeat ? streak_inc : 8'd1;

        bip_fill = !hit_reg && !stream_calc && !lip_leader;
        bim_inc  = bim_reg + 5'd1;
        if (bip_fill && (bim_inc == '0)) begin
            fill_val = dsacr_pkg::RRPV_NEAR;
        end else begin
            fill_val = dsacr_pkg::RRPV_MAX;
        end

        rrpv_upd = rrpv_rd_reg;
        rrpv_upd[{way_idx, 1'b0} +: 2] = hit_reg ? dsacr_pkg::RRPV_NEAR : fill_val;
        reuse_upd = reuse_rd_reg;
        reuse_upd[way_idx] = hit_reg;

        decay_inc = decay_reg + 12'd1;
    end

    // Memory write port: the execute cycle of an update, or the clearing pass.
    always_comb begin
        wr_addr   = (state_reg == ST_SWEEP) ? sweep_cnt_reg : set_addr;
        rrpv_we   = (state_reg == ST_EXEC) || ((state_reg == ST_SWEEP) && sweep_full_reg);
        stride_we = rrpv_we;
        reuse_we  = (state_reg == ST_EXEC) || (state_reg == ST_SWEEP);
        rd_en     = (state_reg == ST_READ);
        if (state_reg == ST_SWEEP) begin
            rrpv_wd   = '1;
            reuse_wd  = '0;
            stride_wd = '0;
        end else begin
            rrpv_wd   = rrpv_upd;
            reuse_wd  = reuse_upd;
            stride_wd = stride_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (rrpv_we) begin
            rrpv_mem[wr_addr] <= rrpv_wd;
        end
        if (rd_en) begin
            rrpv_rd_reg <= rrpv_mem[set_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (reuse_we) begin
            reuse_mem[wr_addr] <= reuse_wd;
        end
        if (rd_en) begin
            reuse_rd_reg <= reuse_mem[set_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stride_we) begin
            stride_mem[wr_addr] <= stride_wd;
        end
        if (rd_en) begin
            stride_rd_reg <= stride_mem[set_addr];
        end
    end

    // Sequencer and architectural state.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        hit_next        = hit_reg;
        set_next        = set_reg;
        way_next        = way_reg;
        addr_next       = addr_reg;
        step_next       = step_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_full_next = sweep_full_reg;
        decay_wrap_next = decay_wrap_reg;
        victim_next     = victim_reg;
        stream_next     = stream_reg;
        thresh_next     = thresh_reg;
        sel_next        = sel_reg;
        bim_next        = bim_reg;
        decay_next      = decay_reg;
        m_valid_next    = m_valid_reg;
        m_way_next      = m_way_reg;
        m_stream_next   = m_stream_reg;

        if (cfg_valid) begin
            thresh_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[0];
                    hit_next   = s_tuser[1];
                    set_next   = s_tdata[SIN_W-1:0];
                    way_next   = s_tdata[SIN_W +: WIN_W];
                    addr_next  = s_tdata[SIN_W + WIN_W +: dsacr_pkg::ADDR_W];
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                // Fold set and way into range, one subtraction per cycle.
                if (!set_in_range) begin
                    set_next = set_reg - SIN_W'(NUM_SETS);
                end
                if (!way_in_range) begin
                    way_next = way_reg - WIN_W'(NUM_WAYS);
                end
                if (set_in_range && way_in_range) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                step_next  = '0;
                state_next = (cmd_reg == dsacr_pkg::CMD_UPDATE) ? ST_EXEC : ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_found || (step_reg == SCAN_FALLBACK)) begin
                    victim_next = scan_found ? scan_way : '0;
                    stream_next = 1'b0;
                    state_next  = ST_FINISH;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EXEC: begin
                victim_next     = '0;
                stream_next     = stream_calc;
                decay_next      = decay_inc;
                decay_wrap_next = (decay_inc == '0);
                if (bip_fill) begin
                    bim_next = bim_inc;
                end
                if (hit_reg && !stream_calc) begin
                    if (lip_leader && (sel_reg < SEL_MAX)) begin
                        sel_next = sel_reg + SEL_W'(1);
                    end
                    if (!lip_leader && (sel_reg != '0)) begin
                        sel_next = sel_reg - SEL_W'(1);
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_way_next    = WIN_W'(victim_reg);
                    m_stream_next = stream_reg;
                    if (decay_wrap_reg) begin
                        decay_wrap_next = 1'b0;
                        sweep_full_next = 1'b0;
                        sweep_cnt_next  = '0;
                        state_next      = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                sweep_cnt_next = sweep_cnt_reg + SET_W'(1);
                if (sweep_cnt_reg == SWEEP_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_full_reg <= 1'b1;
            decay_wrap_reg <= 1'b0;
            thresh_reg     <= dsacr_pkg::THRESH_RESET;
            sel_reg        <= SEL_RESET;
            bim_reg        <= '0;
            decay_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_full_reg <= sweep_full_next;
            decay_wrap_reg <= decay_wrap_next;
            thresh_reg     <= thresh_next;
            sel_reg        <= sel_next;
            bim_reg        <= bim_next;
            decay_reg      <= decay_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Item payload and result registers need no reset.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        hit_reg      <= hit_next;
        set_reg      <= set_next;
        way_reg      <= way_next;
        addr_reg     <= addr_next;
        step_reg     <= step_next;
        victim_reg   <= victim_next;
        stream_reg   <= stream_next;
        m_way_reg    <= m_way_next;
        m_stream_reg <= m_stream_next;
    end

    // No item may enter while the row memories are being cleared.
    `DSACR_ASSERT_SAME(a_no_accept_in_sweep, state_reg == ST_SWEEP, !s_tready, "accept during sweep")
    // A query never reports a streaming verdict.
    `DSACR_ASSERT_SAME(a_query_not_stream, (state_reg == ST_FINISH) && (cmd_reg == dsacr_pkg::CMD_QUERY), !stream_reg, "query marked streaming")
    // A streaming update leaves the policy selector alone.
    `DSACR_ASSERT_NEXT(a_sel_hold_stream, (state_reg == ST_EXEC) && stream_calc, $stable(sel_reg), "selector moved on streaming update")
    // The scan never runs past its fallback pass.
    `DSACR_ASSERT_SAME(a_scan_bounded, state_reg == ST_SCAN, step_reg <= SCAN_FALLBACK, "scan step out of range")

endmodule

FILE: bench/dip_stream_aware_cache_replacement_tb.sv
`timescale 1ns / 100ps

module dip_stream_aware_cache_replacement_tb;

    localparam int POOL_SIZE   = 8;
    localparam int SET_BITS    = dsacr_pkg::SET_IN_W;
    localparam int WAY_BITS    = dsacr_pkg::WAY_IN_W;
    localparam int ADDR_BITS   = dsacr_pkg::ADDR_W;
    localparam int STREAK_BITS = dsacr_pkg::STREAK_W;
    localparam int N_SETS      = dsacr_pkg::NUM_SETS_DEF;
    localparam int N_WAYS      = dsacr_pkg::NUM_WAYS_DEF;

    // One access as it travels on the input stream.
    typedef struct packed {
        logic                cmd;
        logic                hit;
        logic [SET_BITS-1:0] set_idx;
        logic [WAY_BITS-1:0] way;
        logic [ADDR_BITS-1:0] addr_bits;
    } access_t;

    // One verdict as it leaves on the result stream.
    typedef struct packed {
        logic [WAY_BITS-1:0] victim_way;
        logic                stream_detected;
    } verdict_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [31:0] s_tdata  = '0;   // set_index, way, address bits, zero pad
    logic [1:0] s_tuser   = '0;   // cmd, hit
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;          // victim_way, zero pad
    logic       m_tuser;          // stream_detected
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;   // stream_threshold

    // Stimulus and prediction stores.
    access_t  pending_accesses[$];
    verdict_t predicted_verdicts[$];
    access_t  beat_on_bus;
    int       beats_sent  = 0;
    int       beats_taken = 0;
    bit       idle_on     = 1'b1;

    // Private copy of the replacement state.
    logic [1:0]                         rrpv_tab [N_SETS][N_WAYS];
    logic [N_WAYS-1:0]                  reuse_tab [N_SETS];
    logic [ADDR_BITS-1:0]               last_addr_tab [N_SETS];
    logic [ADDR_BITS-1:0]               prev_delta_tab [N_SETS];
    logic [STREAK_BITS-1:0]             streak_tab [N_SETS];
    logic [dsacr_pkg::SELECTOR_W-1:0]   psel;
    logic [dsacr_pkg::BIMODAL_W-1:0]    bimodal_cnt;
    logic [dsacr_pkg::DECAY_W-1:0]      decay_cnt;
    logic [dsacr_pkg::THRESH_W-1:0]     stream_thresh;

    // Sets that the random traffic keeps returning to, each with a stride stream.
    logic [SET_BITS-1:0]  pool_set [POOL_SIZE];
    logic [ADDR_BITS-1:0] pool_next [POOL_SIZE];
    logic [ADDR_BITS-1:0] pool_stride [POOL_SIZE];

    int error_count     = 0;
    int queries_taken   = 0;
    int updates_taken   = 0;
    int streams_seen    = 0;
    int threshold_writes = 0;
    int decay_passes    = 0;

    dip_stream_aware_cache_replacement uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 8 ns period.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Works out the verdict of one access and advances the private state.
    function automatic verdict_t predict_verdict(access_t acc);
        verdict_t             res;
        logic [SET_BITS-1:0]  s;
        logic [ADDR_BITS-1:0] delta;
        logic                 streaming;
        logic                 lip;
        bit                   found;
        res       = '0;
        s         = acc.set_idx;
        streaming = 1'b0;
        found     = 1'b0;
        if (acc.cmd == dsacr_pkg::CMD_QUERY) begin
            // Lowest not-reused way at the highest RRPV level wins.
            for (int r = 3; r >= 0; r--) begin
                for (int k = 0; k < N_WAYS; k++) begin
                    if (!found && rrpv_tab[s][k] == r && !reuse_tab[s][k]) begin
                        res.victim_way = WAY_BITS'(k);
                        found = 1'b1;
                    end
                end
            end
            // With every way reused, fall back to the first distant way, else way 0.
            for (int k = 0; k < N_WAYS; k++) begin
                if (!found && rrpv_tab[s][k] == dsacr_pkg::RRPV_MAX) begin
                    res.victim_way = WAY_BITS'(k);
                    found = 1'b1;
                end
            end
            return res;
        end

        // Stride detector on the low address bits.
        delta = acc.addr_bits - last_addr_tab[s];
        if (streak_tab[s] == '0) begin
            prev_delta_tab[s] = delta;
            streak_tab[s]     = STREAK_BITS'(1);
        end else if (delta == prev_delta_tab[s] && delta != '0) begin
            streak_tab[s] = streak_tab[s] + STREAK_BITS'(1);
            streaming     = (streak_tab[s] >= stream_thresh);
        end else begin
            prev_delta_tab[s] = delta;
            streak_tab[s]     = STREAK_BITS'(1);
        end
        last_addr_tab[s] = acc.addr_bits;

        // Every set leads: the lower half of each group is LIP, the upper half BIP.
        lip = (s % dsacr_pkg::LEADER_GROUP) < (dsacr_pkg::LEADER_GROUP / 2);
        if (!acc.hit) begin
            if (streaming || lip) begin
                rrpv_tab[s][acc.way] = dsacr_pkg::RRPV_MAX;
            end else begin
                bimodal_cnt = bimodal_cnt + 1'b1;
                rrpv_tab[s][acc.way] = (bimodal_cnt == '0) ? dsacr_pkg::RRPV_NEAR
                                                           : dsacr_pkg::RRPV_MAX;
            end
            reuse_tab[s][acc.way] = 1'b0;
        end else begin
            rrpv_tab[s][acc.way]  = dsacr_pkg::RRPV_NEAR;
            reuse_tab[s][acc.way] = 1'b1;
            if (!streaming) begin
                if (lip && psel < dsacr_pkg::SELECTOR_MAX)
                    psel = psel + 1'b1;
                else if (!lip && psel > 0)
                    psel = psel - 1'b1;
            end
        end

        // Periodic decay of all reuse marks.
        decay_cnt = decay_cnt + 1'b1;
        if (decay_cnt == '0) begin
            foreach (reuse_tab[i])
                reuse_tab[i] = '0;
            decay_passes++;
        end
        res.stream_detected = streaming;
        return res;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic void queue_access(logic cmd, int set_i, int way_i, int addr_i, logic hit);
        access_t acc;
        acc.cmd       = cmd;
        acc.hit       = hit;
        acc.set_idx   = set_i[SET_BITS-1:0];
        acc.way       = way_i[WAY_BITS-1:0];
        acc.addr_bits = addr_i[ADDR_BITS-1:0];
        pending_accesses.push_back(acc);
    endfunction

    // Mostly strided updates and queries on the pool sets, with some noise.
    task automatic queue_random_mix(int count);
        int p;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            p    = $urandom_range(POOL_SIZE - 1);
            if (roll < 10) begin
                queue_access(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(15),
                             $urandom_range(65535), 1'($urandom_range(1)));
            end else if (roll < 38) begin
                queue_access(dsacr_pkg::CMD_QUERY, pool_set[p], $urandom_range(15),
                             $urandom_range(65535), 1'($urandom_range(1)));
            end else if (roll < 83) begin
                // Now and then the stream changes stride, sometimes to a large one.
                if ($urandom_range(24) == 0)
                    pool_stride[p] = ($urandom_range(3) == 0)
                                     ? ADDR_BITS'($urandom_range(65535))
                                     : ADDR_BITS'($urandom_range(1, 64));
                queue_access(dsacr_pkg::CMD_UPDATE, pool_set[p], $urandom_range(15),
                             pool_next[p], 1'($urandom_range(1)));
                pool_next[p] = pool_next[p] + pool_stride[p];
            end else begin
                queue_access(dsacr_pkg::CMD_UPDATE, pool_set[p], $urandom_range(15),
                             $urandom_range(65535), 1'($urandom_range(1)));
            end
        end
    endtask

    // Returns once every queued beat has gone in and every verdict has come out.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_accesses.size() != 0 || s_tvalid || predicted_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_threshold(logic [dsacr_pkg::THRESH_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        stream_thresh = value;
        threshold_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: holds a beat until it is taken, then loads the next or idles.
    always @(negedge aclk) begin
        if (aresetn && (beats_taken == beats_sent)) begin
            if (pending_accesses.size() != 0 && !(idle_on && $urandom_range(99) < 11)) begin
                beat_on_bus = pending_accesses.pop_front();
                s_tdata  <= {1'b0, beat_on_bus.addr_bits, beat_on_bus.way, beat_on_bus.set_idx};
                s_tuser  <= {beat_on_bus.hit, beat_on_bus.cmd};
                s_tvalid <= 1'b1;
                beats_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted input beat gets its verdict predicted at once.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predicted_verdicts.push_back(predict_verdict(beat_on_bus));
            beats_taken++;
            if (beat_on_bus.cmd == dsacr_pkg::CMD_QUERY)
                queries_taken++;
            else
                updates_taken++;
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= !(idle_on && $urandom_range(99) < 11);
    end

    // Result monitor: compares each result beat with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.victim_way      = m_tdata[WAY_BITS-1:0];
            got.stream_detected = m_tuser;
            if (got.stream_detected === 1'b1)
                streams_seen++;
            if (predicted_verdicts.size() == 0) begin
                note_error($sformatf("result beat with nothing pending: victim %0d stream %0b",
                                     got.victim_way, got.stream_detected));
            end else begin
                want = predicted_verdicts.pop_front();
                if (got.victim_way !== want.victim_way ||
                    got.stream_detected !== want.stream_detected)
                    note_error($sformatf("victim exp %0d got %0d, stream exp %0b got %0b",
                                         want.victim_way, got.victim_way,
                                         want.stream_detected, got.stream_detected));
            end
        end
    end

    // Main sequence: reset, directed checks, then phases of random traffic.
    initial begin
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] stride;

        // State after reset.
        foreach (rrpv_tab[i, j])
            rrpv_tab[i][j] = dsacr_pkg::RRPV_MAX;
        foreach (reuse_tab[i]) begin
            reuse_tab[i]      = '0;
            last_addr_tab[i]  = '0;
            prev_delta_tab[i] = '0;
            streak_tab[i]     = '0;
        end
        psel          = dsacr_pkg::SELECTOR_W'(dsacr_pkg::SELECTOR_MAX / 2);
        bimodal_cnt   = '0;
        decay_cnt     = '0;
        stream_thresh = dsacr_pkg::THRESH_RESET;

        // Pool sets alternate between LIP and BIP halves of their group.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_set[i]    = {5'($urandom_range(31)), i[0], 5'($urandom_range(31))};
            pool_next[i]   = ADDR_BITS'($urandom_range(65535));
            pool_stride[i] = ADDR_BITS'($urandom_range(1, 64));
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fresh set, then an LIP fill and a hit on the extreme ways.
        queue_access(dsacr_pkg::CMD_QUERY, 0, 0, 0, 1'b0);
        queue_access(dsacr_pkg::CMD_UPDATE, 0, 15, 16'hFFFF, 1'b0);
        queue_access(dsacr_pkg::CMD_UPDATE, 0, 0, 0, 1'b1);
        queue_access(dsacr_pkg::CMD_QUERY, 0, 15, 16'hFFFF, 1'b1);
        // Top set sits in a BIP leader half.
        queue_access(dsacr_pkg::CMD_UPDATE, 2047, 3, 16'h8000, 1'b0);
        queue_access(dsacr_pkg::CMD_UPDATE, 2047, 3, 16'h7FFF, 1'b1);
        queue_access(dsacr_pkg::CMD_QUERY, 2047, 0, 0, 1'b0);
        // A steady stride that wraps past the top of the address range, then a zero delta.
        for (int k = 0; k < 6; k++)
            queue_access(dsacr_pkg::CMD_UPDATE, 1365, k, 16'hFFA0 + k * 16'h20, k[0]);
        queue_access(dsacr_pkg::CMD_UPDATE, 1365, 6, 16'h0040, 1'b1);
        queue_access(dsacr_pkg::CMD_QUERY, 1365, 0, 0, 1'b0);
        // Every way of one set reused: the query falls back to way 0.
        for (int k = 0; k < N_WAYS; k++)
            queue_access(dsacr_pkg::CMD_UPDATE, 672, k, $urandom_range(65535), 1'b1);
        queue_access(dsacr_pkg::CMD_QUERY, 672, 0, 0, 1'b0);

        queue_random_mix(400);
        wait_drained();

        // A threshold of one, and a long stretch with no idling on either side.
        write_threshold(8'd1);
        idle_on = 1'b0;
        queue_random_mix(250);
        wait_drained();
        idle_on = 1'b1;

        // Highest threshold with one stride run long enough to wrap the streak.
        write_threshold(8'd255);
        stride = ADDR_BITS'($urandom_range(1, 4096));
        addr   = ADDR_BITS'($urandom_range(65535));
        for (int k = 0; k < 262; k++) begin
            queue_access(dsacr_pkg::CMD_UPDATE, pool_set[0], $urandom_range(15), addr,
                         1'($urandom_range(1)));
            addr = addr + stride;
        end
        queue_random_mix(80);
        wait_drained();

        // A threshold of zero flags every repeated stride.
        write_threshold(8'd0);
        queue_random_mix(250);
        wait_drained();

        // Mid-range threshold.
        write_threshold(8'($urandom_range(2, 254)));
        queue_random_mix(150);
        wait_drained();

        // Back to the reset value for a last stretch.
        write_threshold(dsacr_pkg::THRESH_RESET);
        queue_random_mix(100);
        wait_drained();
        repeat (50) @(posedge aclk);

        if (predicted_verdicts.size() != 0)
            note_error($sformatf("%0d verdicts never arrived", predicted_verdicts.size()));
        $display("Ran %0d victim queries and %0d updates over %0d threshold settings.",
                 queries_taken, updates_taken, threshold_writes + 1);
        $display("%0d results flagged streaming, reuse marks decayed %0d time(s), %0d errors.",
                 streams_seen, decay_passes, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8000000;
        $display("Run stopped by the watchdog with %0d beats pending.",
                 pending_accesses.size() + predicted_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
